@@ hdl/ewh_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_pkg: shared types and constants of the equal-width histogram
// Widths, register indexes, queue item format and saturating helpers.
// ---------------------------------------------------------------------------
package ewh_pkg;

	localparam int NUM_BUCKETS = 256;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 32;
	localparam int SAMPLE_W    = 32;
	localparam int BC_W        = 9;
	localparam int PROD_W      = SAMPLE_W + BC_W;
	localparam int REG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_RANGE_MIN    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_MAX    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd2;

	// command codes of an input request
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// kind of work handed from the front to the back
	typedef logic [1:0] op_kind_t;
	localparam op_kind_t OP_HIT  = 2'd0;
	localparam op_kind_t OP_MISS = 2'd1;
	localparam op_kind_t OP_READ = 2'd2;

	typedef struct packed {
		op_kind_t         kind;
		logic [IDX_W-1:0] idx;
	} op_t;

	// settings seen by the front, with the bucket count already limited
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] range_min;
		logic signed [SAMPLE_W-1:0] range_max;
		logic [BC_W-1:0]            n;
	} cfg_t;

	function automatic logic [BC_W-1:0] active_buckets(input logic [BC_W-1:0] bc);
		logic [BC_W-1:0] n;
		n = bc;
		if (bc == '0)
			n = BC_W'(1);
		else if (bc > BC_W'(NUM_BUCKETS))
			n = BC_W'(NUM_BUCKETS);
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_W'(1);
	endfunction

endpackage

@@ hdl/ewh_item_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_item_if: input request channel
// Valid/ready channel carrying one command with its sample or bucket index.
// ---------------------------------------------------------------------------
interface ewh_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 cmd;
	logic signed [ewh_pkg::SAMPLE_W-1:0]  sample;
	logic [ewh_pkg::IDX_W-1:0]            read_index;

	modport source (output valid, output cmd, output sample, output read_index, input ready);
	modport sink   (input valid, input cmd, input sample, input read_index, output ready);
endinterface

@@ hdl/ewh_result_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_result_if: result channel
// Valid/ready channel carrying one result with the bucket and both totals.
// ---------------------------------------------------------------------------
interface ewh_result_if;
	logic                        valid;
	logic                        ready;
	logic [ewh_pkg::IDX_W-1:0]   bucket_index;
	logic                        in_range;
	logic [ewh_pkg::CNT_W-1:0]   bucket_value;
	logic [ewh_pkg::CNT_W-1:0]   nodata_total;
	logic [ewh_pkg::CNT_W-1:0]   valid_total;

	modport source (output valid, output bucket_index, output in_range, output bucket_value,
		output nodata_total, output valid_total, input ready);
	modport sink   (input valid, input bucket_index, input in_range, input bucket_value,
		input nodata_total, input valid_total, output ready);
endinterface

@@ hdl/ewh_cfg_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ---------------------------------------------------------------------------
interface ewh_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ewh_pkg::REG_IDX_W-1:0]   index;
	logic [ewh_pkg::SAMPLE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/ewh_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_front: request intake and bucket classification
// Tests a sample against the range and finds its bucket with a multiply
// and a restoring divider that yields one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ewh_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ewh_pkg::cfg_t   cfg_vals,
	ewh_item_if.sink        item,
	output logic            push_valid,
	input  logic            push_ready,
	output ewh_pkg::op_t    push_op
);
	import ewh_pkg::*;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_CLASS = 3'd1;
	localparam logic [2:0] F_MUL   = 3'd2;
	localparam logic [2:0] F_DIV   = 3'd3;
	localparam logic [2:0] F_PUSH  = 3'd4;

	logic [2:0]                 state_q;
	logic                       cmd_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]           rd_idx_q;
	logic [SAMPLE_W-1:0]        off_q;
	logic [SAMPLE_W-1:0]        span_q;
	logic [PROD_W-1:0]          rem_q;
	logic [PROD_W-1:0]          div_q;
	logic [BC_W-1:0]            quo_q;
	logic [3:0]                 step_q;
	op_kind_t                   kind_q;
	logic [IDX_W-1:0]           idx_q;

	logic                       outside;
	logic [SAMPLE_W-1:0]        off_c;
	logic [SAMPLE_W-1:0]        span_c;
	logic                       ge;
	logic [BC_W-1:0]            quo_next;
	logic [BC_W-1:0]            n_m1;

	// range test and offsets from the latched sample
	assign outside = (cfg_vals.range_min > cfg_vals.range_max) ||
		(sample_q < cfg_vals.range_min) || (sample_q > cfg_vals.range_max);
	assign off_c   = $unsigned(sample_q) - $unsigned(cfg_vals.range_min);
	assign span_c  = $unsigned(cfg_vals.range_max) - $unsigned(cfg_vals.range_min);

	// one restoring divider step
	assign ge       = (rem_q >= div_q);
	assign quo_next = {quo_q[BC_W-2:0], ge};
	assign n_m1     = cfg_vals.n - BC_W'(1);

	assign item.ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_op    = '{kind: kind_q, idx: idx_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (item.valid)
						state_q <= F_CLASS;
				end
				F_CLASS: begin
					if (cmd_q == CMD_READ || outside || span_c == '0)
						state_q <= F_PUSH;
					else
						state_q <= F_MUL;
				end
				F_MUL: state_q <= F_DIV;
				F_DIV: begin
					if (step_q == '0)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				cmd_q    <= item.cmd;
				sample_q <= item.sample;
				rd_idx_q <= item.read_index;
			end
			F_CLASS: begin
				off_q  <= off_c;
				span_q <= span_c;
				idx_q  <= '0;
				if (cmd_q == CMD_READ) begin
					kind_q <= OP_READ;
					idx_q  <= rd_idx_q;
				end else if (outside) begin
					kind_q <= OP_MISS;
				end else begin
					kind_q <= OP_HIT;
				end
			end
			F_MUL: begin
				rem_q  <= PROD_W'(off_q) * PROD_W'(cfg_vals.n);
				div_q  <= {1'b0, span_q, {IDX_W{1'b0}}};
				quo_q  <= '0;
				step_q <= 4'(IDX_W);
			end
			F_DIV: begin
				if (ge)
					rem_q <= rem_q - div_q;
				div_q  <= div_q >> 1;
				quo_q  <= quo_next;
				step_q <= step_q - 4'd1;
				// clamp to the last bucket in use
				if (step_q == '0)
					idx_q <= (quo_next > n_m1) ? n_m1[IDX_W-1:0] : quo_next[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	a_hit_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH && kind_q == OP_HIT) |-> ({1'b0, idx_q} < cfg_vals.n))
		else $error("bucket index beyond buckets in use");

	a_div_ends_in_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV && step_q == '0) |=> (state_q == F_PUSH && kind_q == OP_HIT))
		else $error("divider did not hand over a hit");

endmodule

@@ hdl/ewh_fifo.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_fifo: short queue between front and back
// Holds classified requests so that either side may stall on its own.
// ---------------------------------------------------------------------------
module ewh_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ewh_pkg::op_t  push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ewh_pkg::op_t  pop_op
);
	import ewh_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	// store pushed request
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_op;
	end

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue overfilled");

endmodule

@@ hdl/ewh_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ewh_back: bucket store and result stage
// Reads the bucket, increments it with saturation, keeps both totals and
// presents each result in an output register.
// ---------------------------------------------------------------------------
module ewh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  ewh_pkg::op_t  pop_op,
	ewh_result_if.source  result
);
	import ewh_pkg::*;

	localparam logic B_IDLE = 1'b0;
	localparam logic B_UPD  = 1'b1;

	logic [CNT_W-1:0]   mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] vld_q;
	logic               state_q;
	op_t                op_s1;
	logic [CNT_W-1:0]   rd_s1;
	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic               out_hit_q;
	logic [CNT_W-1:0]   out_val_q;
	logic [CNT_W-1:0]   nodata_cnt_q;
	logic [CNT_W-1:0]   valid_cnt_q;

	logic               do_pop;
	logic               upd_fire;
	logic [CNT_W-1:0]   cur;
	logic [CNT_W-1:0]   inc;
	logic               wr_en;

	assign pop_ready = (state_q == B_IDLE);
	assign do_pop    = pop_valid && pop_ready;
	assign upd_fire  = (state_q == B_UPD) && (!out_valid_q || result.ready);
	// a bucket never written since reset reads as zero
	assign cur       = vld_q[op_s1.idx] ? rd_s1 : '0;
	assign inc       = sat_inc(cur);
	assign wr_en     = upd_fire && (op_s1.kind == OP_HIT);

	assign result.valid        = out_valid_q;
	assign result.bucket_index = out_idx_q;
	assign result.in_range     = out_hit_q;
	assign result.bucket_value = out_val_q;
	assign result.nodata_total = nodata_cnt_q;
	assign result.valid_total  = valid_cnt_q;

	// bucket store: registered read on pop, write back on update
	always_ff @(posedge clk) begin
		if (do_pop) begin
			op_s1 <= pop_op;
			rd_s1 <= mem[pop_op.idx];
		end
		if (wr_en)
			mem[op_s1.idx] <= inc;
	end

	// control, counters and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			out_valid_q  <= 1'b0;
			vld_q        <= '0;
			nodata_cnt_q <= '0;
			valid_cnt_q  <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (do_pop)
						state_q <= B_UPD;
				end
				B_UPD: begin
					if (upd_fire)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
			if (upd_fire)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			if (wr_en) begin
				vld_q[op_s1.idx] <= 1'b1;
				valid_cnt_q      <= sat_inc(valid_cnt_q);
			end
			if (upd_fire && op_s1.kind == OP_MISS)
				nodata_cnt_q <= sat_inc(nodata_cnt_q);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (upd_fire) begin
			case (op_s1.kind)
				OP_HIT: begin
					out_idx_q <= op_s1.idx;
					out_hit_q <= 1'b1;
					out_val_q <= inc;
				end
				OP_READ: begin
					out_idx_q <= op_s1.idx;
					out_hit_q <= 1'b0;
					out_val_q <= cur;
				end
				default: begin
					out_idx_q <= '0;
					out_hit_q <= 1'b0;
					out_val_q <= '0;
				end
			endcase
		end
	end

	a_update_presents: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid_q)
		else $error("update did not present a result");

	a_hit_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(op_s1.idx)])
		else $error("written bucket not marked");

	a_nodata_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_fire |=> ($stable(nodata_cnt_q) && $stable(valid_cnt_q)))
		else $error("totals moved without an update");

	a_valid_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (valid_cnt_q >= $past(valid_cnt_q)))
		else $error("valid total went down");

endmodule

@@ hdl/equal_width_histogram_top.sv @@
`timescale 1ns / 1ps
// Sample requests pass the range test and, when in range with a nonzero span, the multiply and
// the restoring divider that yields one quotient bit per cycle; the front takes a new request
// only after pushing the last one. Read requests skip the multiply and the divider.
// The back reads the bucket store on pop and writes it back on update, one request at a time.
// Reset clears all counters and every bucket valid bit at once; no clearing pass.
// ---------------------------------------------------------------------------
// equal_width_histogram_top: equal-width histogram engine
// Configuration registers, classifying front, request queue and bucket back.
// ---------------------------------------------------------------------------
module equal_width_histogram_top (
	input  logic          clk,
	input  logic          arst_n,
	ewh_item_if.sink      item,
	ewh_result_if.source  result,
	ewh_cfg_if.sink       cfg
);
	import ewh_pkg::*;

	logic signed [SAMPLE_W-1:0] range_min_q;
	logic signed [SAMPLE_W-1:0] range_max_q;
	logic [BC_W-1:0]            bucket_count_q;
	cfg_t                       cfg_vals;

	logic push_valid;
	logic push_ready;
	op_t  push_op;
	logic pop_valid;
	logic pop_ready;
	op_t  pop_op;

	assign cfg.ready = 1'b1;
	assign cfg_vals  = '{range_min: range_min_q, range_max: range_max_q,
		n: active_buckets(bucket_count_q)};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q    <= '0;
			range_max_q    <= SAMPLE_W'(32'sd16777216);
			bucket_count_q <= BC_W'(NUM_BUCKETS);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RANGE_MIN:    range_min_q    <= cfg.data;
				REG_RANGE_MAX:    range_max_q    <= cfg.data;
				REG_BUCKET_COUNT: bucket_count_q <= cfg.data[BC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ewh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_vals   (cfg_vals),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	ewh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	ewh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.result    (result)
	);

endmodule
